// ===== rtl/gspd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the generational slot pool: operation, status and slot codes,
// the slot record kept in memory and the configuration bundle. No dependencies.
package gspd_pkg;

    localparam int SLOT_COUNT_DEF = 512;
    localparam int IDX_W          = 10;
    localparam int GEN_W          = 32;
    localparam int POOL_W         = 64;
    localparam int SER_W          = 64;
    localparam int CELL_W         = 17;
    localparam int FACE_W         = 19;
    localparam int NODE_W         = 18;
    localparam int BYTE_W         = 26;
    localparam int CNT_W          = 10;
    localparam int RUN_LIMIT      = 512;
    localparam int CFG_IDX_W      = 3;

    typedef enum logic [2:0] {
        OP_INSERT   = 3'd0,
        OP_LOOKUP   = 3'd1,
        OP_RETAIN   = 3'd2,
        OP_RELEASE  = 3'd3,
        OP_RETIRE   = 3'd4,
        OP_SUBMIT   = 3'd5,
        OP_EMPTY    = 3'd6,
        OP_COMPLETE = 3'd7
    } t_op;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_BAD_PROFILE = 4'd1,
        ST_BAD_SHAPE   = 4'd2,
        ST_CAPACITY    = 4'd3,
        ST_GEN_EXH     = 4'd4,
        ST_BAD_HANDLE  = 4'd5,
        ST_RETIRING    = 4'd6,
        ST_REF_OVF     = 4'd7,
        ST_NO_REF      = 4'd8,
        ST_BAD_SUBMIT  = 4'd9
    } t_status;

    typedef enum logic [1:0] {
        SL_FREE      = 2'd0,
        SL_RESIDENT  = 2'd1,
        SL_RETIRING  = 2'd2,
        SL_EXHAUSTED = 2'd3
    } t_slot_st;

    typedef enum logic [2:0] {
        CFG_POOL     = 3'd0,
        CFG_MAX_GEN  = 3'd1,
        CFG_B_CELLS  = 3'd2,
        CFG_B_FACES  = 3'd3,
        CFG_B_NODES  = 3'd4,
        CFG_B_BYTES  = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        FS_CLEAR,
        FS_IDLE,
        FS_DISPATCH,
        FS_ACCESS,
        FS_FIN,
        FS_SWEEP
    } t_fsm;

    typedef enum logic [1:0] {
        SW_SCAN,
        SW_RECLAIM,
        SW_FINISH
    } t_sweep;

    // One slot as held in the slot memory.
    typedef struct packed {
        logic              mark;
        t_slot_st          st;
        logic [GEN_W-1:0]  gen;
        logic [31:0]       refs;
        logic [SER_W-1:0]  last;
        logic [CELL_W-1:0] c_cells;
        logic [FACE_W-1:0] c_faces;
        logic [NODE_W-1:0] c_nodes;
        logic [BYTE_W-1:0] c_bytes;
    } t_entry;

    typedef struct packed {
        logic [POOL_W-1:0] pool;
        logic [GEN_W-1:0]  max_gen;
        logic [CELL_W-1:0] b_cells;
        logic [FACE_W-1:0] b_faces;
        logic [NODE_W-1:0] b_nodes;
        logic [BYTE_W-1:0] b_bytes;
    } t_cfg;

    localparam t_entry ENTRY_RESET = '{
        mark: 1'b0, st: SL_FREE, gen: 32'd1, refs: 32'd0, last: 64'd0,
        c_cells: '0, c_faces: '0, c_nodes: '0, c_bytes: '0
    };

endpackage

// ===== rtl/gspd_mem.sv =====
`timescale 1ns / 1ps
// Slot memory: one write port, one read port with registered read data.
// Depends on gspd_pkg for the slot record type.
module gspd_mem
    import gspd_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  t_entry              i_wdata,
    input  logic                i_re,
    input  logic [AW-1:0]       i_raddr,
    output t_entry              o_rdata
);
    t_entry r_mem [SLOT_COUNT];
    t_entry r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/gspd_core.sv =====
`timescale 1ns / 1ps
// Sequencer and datapath of the slot pool: per-operation read-modify-write
// of one slot and whole-memory sweeps. Depends on gspd_pkg and drives gspd_mem.
module gspd_core
    import gspd_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  t_cfg                i_cfg,
    input  logic [2:0]          i_operation,
    input  logic [IDX_W-1:0]    i_handle_index,
    input  logic [GEN_W-1:0]    i_handle_generation,
    input  logic [POOL_W-1:0]   i_handle_pool,
    input  logic [CELL_W-1:0]   i_cost_cells,
    input  logic [FACE_W-1:0]   i_cost_faces,
    input  logic [NODE_W-1:0]   i_cost_nodes,
    input  logic [BYTE_W-1:0]   i_cost_bytes,
    input  logic [SER_W-1:0]    i_serial,
    input  logic                i_last_handle,
    output logic                o_done,
    output logic [3:0]          o_status,
    output logic [IDX_W-1:0]    o_new_index,
    output logic [GEN_W-1:0]    o_new_generation,
    output logic [CNT_W-1:0]    o_resident_count,
    output logic [CNT_W-1:0]    o_retiring_count,
    output logic                o_mem_we,
    output logic [AW-1:0]       o_mem_waddr,
    output t_entry              o_mem_wdata,
    output logic                o_mem_re,
    output logic [AW-1:0]       o_mem_raddr,
    input  t_entry              i_mem_rdata
);
    t_fsm               r_state, n_state;
    t_op                r_op;
    logic [IDX_W-1:0]   r_idx;
    logic [GEN_W-1:0]   r_gen;
    logic [POOL_W-1:0]  r_pool;
    logic [CELL_W-1:0]  r_cost_cells;
    logic [FACE_W-1:0]  r_cost_faces;
    logic [NODE_W-1:0]  r_cost_nodes;
    logic [BYTE_W-1:0]  r_cost_bytes;
    logic [SER_W-1:0]   r_serial;
    logic               r_last;

    logic               r_run_open, n_run_open;
    logic [SER_W-1:0]   r_run_serial, n_run_serial;
    logic [CNT_W-1:0]   r_run_count, n_run_count;
    t_status            r_run_err, n_run_err;
    t_status            r_fin_st, n_fin_st;
    logic [SER_W-1:0]   r_submitted, n_submitted;
    logic [SER_W-1:0]   r_completed, n_completed;

    logic [CELL_W-1:0]  r_ch_cells, n_ch_cells;
    logic [FACE_W-1:0]  r_ch_faces, n_ch_faces;
    logic [NODE_W-1:0]  r_ch_nodes, n_ch_nodes;
    logic [BYTE_W-1:0]  r_ch_bytes, n_ch_bytes;
    logic [CNT_W-1:0]   r_resident, n_resident;
    logic [CNT_W-1:0]   r_retiring, n_retiring;
    logic [CNT_W-1:0]   r_exhausted, n_exhausted;

    logic [AW:0]        r_addr, n_addr;
    logic               r_pend, n_pend;
    logic [AW-1:0]      r_paddr, n_paddr;
    t_sweep             r_mode, n_mode;
    logic               r_hok, n_hok;

    logic               r_done, n_done;
    t_status            r_status, n_status;
    logic [IDX_W-1:0]   r_new_index, n_new_index;
    logic [GEN_W-1:0]   r_new_gen, n_new_gen;

    logic [CELL_W-1:0]  w_room_cells;
    logic [FACE_W-1:0]  w_room_faces;
    logic [NODE_W-1:0]  w_room_nodes;
    logic [BYTE_W-1:0]  w_room_bytes;
    logic               w_ins_fail;
    logic               w_cmp_fail;
    logic               w_valid;
    logic               w_last;
    logic               w_free_hit;
    logic               w_clear_end;

    // Remaining room in each budget, zero where the budget was lowered below the charge.
    assign w_room_cells = (i_cfg.b_cells > r_ch_cells) ? i_cfg.b_cells - r_ch_cells : '0;
    assign w_room_faces = (i_cfg.b_faces > r_ch_faces) ? i_cfg.b_faces - r_ch_faces : '0;
    assign w_room_nodes = (i_cfg.b_nodes > r_ch_nodes) ? i_cfg.b_nodes - r_ch_nodes : '0;
    assign w_room_bytes = (i_cfg.b_bytes > r_ch_bytes) ? i_cfg.b_bytes - r_ch_bytes : '0;

    // Early refusal of an insert or a completion, before any sweep starts.
    assign w_ins_fail = (i_cfg.pool == '0) || (r_cost_cells == '0) || (r_cost_faces == '0)
                     || (r_cost_nodes == '0) || (r_cost_cells > w_room_cells)
                     || (r_cost_faces > w_room_faces) || (r_cost_nodes > w_room_nodes)
                     || (r_cost_bytes > w_room_bytes);
    assign w_cmp_fail = (i_cfg.pool == '0) || (r_serial < r_completed)
                     || (r_serial > r_submitted);

    // Handle check against the slot just read.
    assign w_valid = r_hok && (i_mem_rdata.gen == r_gen)
                  && ((i_mem_rdata.st == SL_RESIDENT) || (i_mem_rdata.st == SL_RETIRING));

    // Sweep pipeline status.
    assign w_last      = r_pend && (r_paddr == AW'(SLOT_COUNT - 1));
    assign w_free_hit  = (r_mode == SW_SCAN) && r_pend && (i_mem_rdata.st == SL_FREE);
    assign w_clear_end = (r_addr[AW-1:0] == AW'(SLOT_COUNT - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_CLEAR: begin
                if (w_clear_end) n_state = FS_IDLE;
            end
            FS_IDLE: begin
                if (start) n_state = FS_DISPATCH;
            end
            FS_DISPATCH: begin
                case (r_op)
                    OP_INSERT:   n_state = w_ins_fail ? FS_IDLE : FS_SWEEP;
                    OP_EMPTY:    n_state = FS_FIN;
                    OP_COMPLETE: n_state = w_cmp_fail ? FS_IDLE : FS_SWEEP;
                    default:     n_state = FS_ACCESS;
                endcase
            end
            FS_ACCESS: begin
                n_state = ((r_op == OP_SUBMIT) && r_last) ? FS_FIN : FS_IDLE;
            end
            FS_FIN: begin
                n_state = FS_SWEEP;
            end
            FS_SWEEP: begin
                if (w_free_hit || w_last) n_state = FS_IDLE;
            end
            default: n_state = FS_IDLE;
        endcase
    end

    // Datapath, memory requests and results.
    always_comb begin
        t_entry e;
        t_entry ne;
        logic   rc_en;
        e             = i_mem_rdata;
        ne            = i_mem_rdata;
        rc_en         = 1'b0;
        n_run_open    = r_run_open;
        n_run_serial  = r_run_serial;
        n_run_count   = r_run_count;
        n_run_err     = r_run_err;
        n_fin_st      = r_fin_st;
        n_submitted   = r_submitted;
        n_completed   = r_completed;
        n_ch_cells    = r_ch_cells;
        n_ch_faces    = r_ch_faces;
        n_ch_nodes    = r_ch_nodes;
        n_ch_bytes    = r_ch_bytes;
        n_resident    = r_resident;
        n_retiring    = r_retiring;
        n_exhausted   = r_exhausted;
        n_addr        = r_addr;
        n_pend        = 1'b0;
        n_paddr       = r_paddr;
        n_mode        = r_mode;
        n_hok         = r_hok;
        n_done        = 1'b0;
        n_status      = ST_OK;
        n_new_index   = '0;
        n_new_gen     = '0;
        o_mem_we      = 1'b0;
        o_mem_waddr   = r_paddr;
        o_mem_wdata   = ENTRY_RESET;
        o_mem_re      = 1'b0;
        o_mem_raddr   = r_addr[AW-1:0];

        case (r_state)
            // Clearing pass after reset, one slot a cycle.
            FS_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_addr[AW-1:0];
                n_addr      = r_addr + 1'b1;
                if (w_clear_end) n_addr = '0;
            end

            FS_IDLE: begin
            end

            // Checks that need no slot, then start the read or the sweep.
            FS_DISPATCH: begin
                n_addr = '0;
                case (r_op)
                    OP_INSERT: begin
                        n_mode = SW_SCAN;
                        if (w_ins_fail) begin
                            n_done = 1'b1;
                            if (i_cfg.pool == '0) begin
                                n_status = ST_BAD_PROFILE;
                            end else if ((r_cost_cells == '0) || (r_cost_faces == '0)
                                         || (r_cost_nodes == '0)) begin
                                n_status = ST_BAD_SHAPE;
                            end else begin
                                n_status = ST_CAPACITY;
                            end
                        end
                    end
                    OP_EMPTY: begin
                        if (!r_run_open) begin
                            n_run_open   = 1'b1;
                            n_run_serial = r_serial;
                            n_run_count  = '0;
                            n_run_err    = ST_OK;
                        end
                    end
                    OP_COMPLETE: begin
                        n_mode = SW_RECLAIM;
                        if (w_cmp_fail) begin
                            n_done   = 1'b1;
                            n_status = ST_BAD_SUBMIT;
                        end else begin
                            n_completed = r_serial;
                        end
                    end
                    default: begin
                        n_hok = (i_cfg.pool != '0) && (r_pool == i_cfg.pool)
                             && (r_idx != '0) && (r_idx <= IDX_W'(SLOT_COUNT));
                        o_mem_re    = 1'b1;
                        o_mem_raddr = AW'(r_idx - 1'b1);
                        n_paddr     = AW'(r_idx - 1'b1);
                        if ((r_op == OP_SUBMIT) && !r_run_open) begin
                            n_run_open   = 1'b1;
                            n_run_serial = r_serial;
                            n_run_count  = '0;
                            n_run_err    = ST_OK;
                        end
                    end
                endcase
            end

            // Modify the one addressed slot and write it back; a lookup only checks the handle.
            FS_ACCESS: begin
                o_mem_waddr = r_paddr;
                case (r_op)
                    OP_LOOKUP: begin
                        n_done   = 1'b1;
                        n_status = w_valid ? ST_OK : ST_BAD_HANDLE;
                    end
                    OP_RETAIN: begin
                        n_done = 1'b1;
                        if (!w_valid) begin
                            n_status = ST_BAD_HANDLE;
                        end else if (e.st != SL_RESIDENT) begin
                            n_status = ST_RETIRING;
                        end else if (e.refs == '1) begin
                            n_status = ST_REF_OVF;
                        end else begin
                            ne.refs  = e.refs + 1'b1;
                            o_mem_we = 1'b1;
                        end
                    end
                    OP_RELEASE: begin
                        n_done = 1'b1;
                        if (!w_valid) begin
                            n_status = ST_BAD_HANDLE;
                        end else if (e.refs == '0) begin
                            n_status = ST_NO_REF;
                        end else begin
                            ne.refs  = e.refs - 1'b1;
                            rc_en    = 1'b1;
                            o_mem_we = 1'b1;
                        end
                    end
                    OP_RETIRE: begin
                        n_done = 1'b1;
                        if (!w_valid) begin
                            n_status = ST_BAD_HANDLE;
                        end else begin
                            if (e.st == SL_RESIDENT) begin
                                ne.st      = SL_RETIRING;
                                n_resident = n_resident - 1'b1;
                                n_retiring = n_retiring + 1'b1;
                                if (r_run_open && e.mark && (r_run_err == ST_OK)) begin
                                    n_run_err = ST_RETIRING;
                                end
                            end
                            rc_en    = 1'b1;
                            o_mem_we = 1'b1;
                        end
                    end
                    OP_SUBMIT: begin
                        if (r_run_count <= CNT_W'(RUN_LIMIT)) n_run_count = r_run_count + 1'b1;
                        if (!w_valid) begin
                            if (r_run_err == ST_OK) n_run_err = ST_BAD_HANDLE;
                        end else if (e.st != SL_RESIDENT) begin
                            if (r_run_err == ST_OK) n_run_err = ST_RETIRING;
                        end else begin
                            ne.mark  = 1'b1;
                            o_mem_we = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // Verdict of a submission run, before its marks are swept.
            FS_FIN: begin
                n_mode = SW_FINISH;
                n_addr = '0;
                if ((i_cfg.pool == '0) || (r_run_serial <= r_submitted)) begin
                    n_fin_st = ST_BAD_SUBMIT;
                end else if (r_run_count > CNT_W'(RUN_LIMIT)) begin
                    n_fin_st = ST_CAPACITY;
                end else begin
                    n_fin_st = r_run_err;
                end
            end

            // Sweep: read slot k while slot k-1 is processed and written back.
            FS_SWEEP: begin
                if (r_addr < (AW+1)'(SLOT_COUNT)) begin
                    o_mem_re = 1'b1;
                    n_addr   = r_addr + 1'b1;
                    n_pend   = 1'b1;
                    n_paddr  = r_addr[AW-1:0];
                end
                if (r_pend) begin
                    o_mem_waddr = r_paddr;
                    case (r_mode)
                        SW_SCAN: begin
                            if (e.st == SL_FREE) begin
                                ne.st       = SL_RESIDENT;
                                ne.last     = '0;
                                ne.refs     = '0;
                                ne.c_cells  = r_cost_cells;
                                ne.c_faces  = r_cost_faces;
                                ne.c_nodes  = r_cost_nodes;
                                ne.c_bytes  = r_cost_bytes;
                                o_mem_we    = 1'b1;
                                n_ch_cells  = r_ch_cells + r_cost_cells;
                                n_ch_faces  = r_ch_faces + r_cost_faces;
                                n_ch_nodes  = r_ch_nodes + r_cost_nodes;
                                n_ch_bytes  = r_ch_bytes + r_cost_bytes;
                                n_resident  = r_resident + 1'b1;
                                n_done      = 1'b1;
                                n_new_index = IDX_W'(r_paddr) + 1'b1;
                                n_new_gen   = e.gen;
                            end else if (w_last) begin
                                n_done   = 1'b1;
                                n_status = (r_exhausted == CNT_W'(SLOT_COUNT)) ?
                                           ST_GEN_EXH : ST_CAPACITY;
                            end
                        end
                        SW_RECLAIM: begin
                            rc_en    = 1'b1;
                            o_mem_we = 1'b1;
                            if (w_last) n_done = 1'b1;
                        end
                        SW_FINISH: begin
                            ne.mark  = 1'b0;
                            if ((r_fin_st == ST_OK) && e.mark) ne.last = r_run_serial;
                            o_mem_we = 1'b1;
                            if (w_last) begin
                                n_done       = 1'b1;
                                n_status     = r_fin_st;
                                if (r_fin_st == ST_OK) n_submitted = r_run_serial;
                                n_run_open   = 1'b0;
                                n_run_count  = '0;
                                n_run_err    = ST_OK;
                                n_run_serial = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                if (w_free_hit || w_last) n_pend = 1'b0;
            end

            default: begin
            end
        endcase

        // Deferred reclamation of a retired slot with no references and a completed serial.
        if (rc_en && (ne.st == SL_RETIRING) && (ne.refs == '0) && (ne.last <= r_completed)) begin
            n_ch_cells = n_ch_cells - ne.c_cells;
            n_ch_faces = n_ch_faces - ne.c_faces;
            n_ch_nodes = n_ch_nodes - ne.c_nodes;
            n_ch_bytes = n_ch_bytes - ne.c_bytes;
            n_retiring = n_retiring - 1'b1;
            if ((ne.gen >= i_cfg.max_gen) || (ne.gen == '1)) begin
                ne.st       = SL_EXHAUSTED;
                n_exhausted = n_exhausted + 1'b1;
            end else begin
                ne.gen = ne.gen + 1'b1;
                ne.st  = SL_FREE;
            end
        end

        if (r_state != FS_CLEAR) o_mem_wdata = ne;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= FS_CLEAR;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_mode      <= SW_SCAN;
            r_run_open  <= 1'b0;
            r_run_serial <= '0;
            r_run_count <= '0;
            r_run_err   <= ST_OK;
            r_fin_st    <= ST_OK;
            r_submitted <= '0;
            r_completed <= '0;
            r_ch_cells  <= '0;
            r_ch_faces  <= '0;
            r_ch_nodes  <= '0;
            r_ch_bytes  <= '0;
            r_resident  <= '0;
            r_retiring  <= '0;
            r_exhausted <= '0;
            r_hok       <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_pend      <= n_pend;
            r_mode      <= n_mode;
            r_run_open  <= n_run_open;
            r_run_serial <= n_run_serial;
            r_run_count <= n_run_count;
            r_run_err   <= n_run_err;
            r_fin_st    <= n_fin_st;
            r_submitted <= n_submitted;
            r_completed <= n_completed;
            r_ch_cells  <= n_ch_cells;
            r_ch_faces  <= n_ch_faces;
            r_ch_nodes  <= n_ch_nodes;
            r_ch_bytes  <= n_ch_bytes;
            r_resident  <= n_resident;
            r_retiring  <= n_retiring;
            r_exhausted <= n_exhausted;
            r_hok       <= n_hok;
            r_done      <= n_done;
        end
    end

    // Payload registers: the accepted transaction and the result.
    always_ff @(posedge i_clk) begin
        r_paddr     <= n_paddr;
        r_status    <= n_status;
        r_new_index <= n_new_index;
        r_new_gen   <= n_new_gen;
        if (start && (r_state == FS_IDLE)) begin
            r_op         <= t_op'(i_operation);
            r_idx        <= i_handle_index;
            r_gen        <= i_handle_generation;
            r_pool       <= i_handle_pool;
            r_cost_cells <= i_cost_cells;
            r_cost_faces <= i_cost_faces;
            r_cost_nodes <= i_cost_nodes;
            r_cost_bytes <= i_cost_bytes;
            r_serial     <= i_serial;
            r_last       <= i_last_handle;
        end
    end

    assign busy             = (r_state != FS_IDLE);
    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_new_index      = r_new_index;
    assign o_new_generation = r_new_gen;
    assign o_resident_count = r_resident;
    assign o_retiring_count = r_retiring;

endmodule

// ===== rtl/generational_slot_pool_deferred_reclaim.sv =====
`timescale 1ns / 1ps
// Top level of the generational slot pool: configuration registers, the
// sequencer and the slot memory. Depends on gspd_pkg, gspd_core and gspd_mem.
//
// Usage:
// - Command channel: a transaction is taken at a rising edge with start high
//   and busy low. Its result, if any, appears for exactly one cycle with
//   o_done high; the receiver cannot stall it. A submit handle that is not
//   the last of its run gives no result and frees the block after dispatch and access.
// - Configuration channel: i_cfg_valid with i_cfg_index and i_cfg_data; the
//   port is always ready. Write only while busy is low and no result is owed.
// - Sequence, acceptance to o_done high: lookup, retain, release and retire
//   read the addressed slot in dispatch and give the result from access. A
//   refused insert or completion gives it from dispatch. Insert walks the slot
//   memory up to the first free slot; completion sweeps every slot; submit
//   empty passes the verdict state and then sweeps; a final submit handle
//   passes access and verdict, then sweeps. Sweeps take one slot a cycle.
// - Throughput: one transaction at a time; busy drops in the cycle that
//   shows the result, so the next one can be taken at the edge ending it.
// - Reset: synchronous, active low. After reset the block clears every slot
//   of the slot memory with busy high; configuration writes are taken during
//   that time.
module generational_slot_pool_deferred_reclaim
    import gspd_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [2:0]            i_operation,
    input  logic [IDX_W-1:0]      i_handle_index,
    input  logic [GEN_W-1:0]      i_handle_generation,
    input  logic [POOL_W-1:0]     i_handle_pool,
    input  logic [CELL_W-1:0]     i_cost_cells,
    input  logic [FACE_W-1:0]     i_cost_faces,
    input  logic [NODE_W-1:0]     i_cost_nodes,
    input  logic [BYTE_W-1:0]     i_cost_bytes,
    input  logic [SER_W-1:0]      i_serial,
    input  logic                  i_last_handle,
    output logic                  o_done,
    output logic [3:0]            o_status,
    output logic [IDX_W-1:0]      o_new_index,
    output logic [GEN_W-1:0]      o_new_generation,
    output logic [CNT_W-1:0]      o_resident_count,
    output logic [CNT_W-1:0]      o_retiring_count,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [63:0]           i_cfg_data
);
    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    t_cfg          r_cfg;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_entry        w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    t_entry        w_rdata;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pool    <= '0;
            r_cfg.max_gen <= '1;
            r_cfg.b_cells <= CELL_W'(65536);
            r_cfg.b_faces <= FACE_W'(393216);
            r_cfg.b_nodes <= NODE_W'(131072);
            r_cfg.b_bytes <= BYTE_W'(33554432);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_POOL:    r_cfg.pool    <= i_cfg_data;
                CFG_MAX_GEN: r_cfg.max_gen <= i_cfg_data[GEN_W-1:0];
                CFG_B_CELLS: r_cfg.b_cells <= i_cfg_data[CELL_W-1:0];
                CFG_B_FACES: r_cfg.b_faces <= i_cfg_data[FACE_W-1:0];
                CFG_B_NODES: r_cfg.b_nodes <= i_cfg_data[NODE_W-1:0];
                CFG_B_BYTES: r_cfg.b_bytes <= i_cfg_data[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    gspd_core #(.SLOT_COUNT(SLOT_COUNT)) u_core (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_cfg               (r_cfg),
        .i_operation         (i_operation),
        .i_handle_index      (i_handle_index),
        .i_handle_generation (i_handle_generation),
        .i_handle_pool       (i_handle_pool),
        .i_cost_cells        (i_cost_cells),
        .i_cost_faces        (i_cost_faces),
        .i_cost_nodes        (i_cost_nodes),
        .i_cost_bytes        (i_cost_bytes),
        .i_serial            (i_serial),
        .i_last_handle       (i_last_handle),
        .o_done              (o_done),
        .o_status            (o_status),
        .o_new_index         (o_new_index),
        .o_new_generation    (o_new_generation),
        .o_resident_count    (o_resident_count),
        .o_retiring_count    (o_retiring_count),
        .o_mem_we            (w_we),
        .o_mem_waddr         (w_waddr),
        .o_mem_wdata         (w_wdata),
        .o_mem_re            (w_re),
        .o_mem_raddr         (w_raddr),
        .i_mem_rdata         (w_rdata)
    );

    gspd_mem #(.SLOT_COUNT(SLOT_COUNT)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Occupancy never exceeds the pool.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, o_resident_count} + {1'b0, o_retiring_count}) <= (CNT_W+1)'(SLOT_COUNT))
        else $error("occupancy exceeds slot count");

    // Only a successful insert returns a handle.
    a_handle_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_new_index != '0)) |-> (o_status == ST_OK))
        else $error("handle returned with failure status");

    // A returned handle points into the pool.
    a_handle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_new_index != '0)) |-> (o_new_index <= IDX_W'(SLOT_COUNT)))
        else $error("returned handle out of range");

    // An accepted transaction makes the block busy at once.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

endmodule
